### hdl/ilie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_pkg: shared types and constants of the indexed list
// Operation codes, status codes and the per-cell operation flags.
// ----------------------------------------------------------------------------
package ilie_pkg;

  localparam int DATA_W = 64;
  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE     = 3'd2;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Operations that passed their checks, broadcast to every cell.
  typedef struct packed {
    logic app;
    logic ins;
    logic ers;
    logic ovw;
    logic rd;
  } cell_ops_t;

endpackage : ilie_pkg
`default_nettype wire

### hdl/ilie_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_cell: one list entry
// Holds one word; loads the new word, takes its left or right neighbor on
// insert or erase, and offers its word when it is the one being read.
// ----------------------------------------------------------------------------
module ilie_cell #(
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire ilie_pkg::cell_ops_t        ops,
  input  wire logic [CW-1:0]              pos,
  input  wire logic [CW-1:0]              cnt,
  input  wire logic [ilie_pkg::DATA_W-1:0] wr_data,
  input  wire logic [ilie_pkg::DATA_W-1:0] left_data,
  input  wire logic [ilie_pkg::DATA_W-1:0] right_data,
  output logic      [ilie_pkg::DATA_W-1:0] data,
  output logic      [ilie_pkg::DATA_W-1:0] rd_data
);
  import ilie_pkg::*;

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;

  assign at_pos = (pos == MY_IDX);

  always_comb begin
    data_nxt = data_r;
    priority if (ops.app && cnt == MY_IDX) begin
      data_nxt = wr_data;
    end else if (ops.ins && at_pos) begin
      data_nxt = wr_data;
    end else if (ops.ins && MY_IDX > pos && MY_IDX <= cnt) begin
      data_nxt = left_data;
    end else if (ops.ers && MY_IDX >= pos && NXT_IDX < cnt) begin
      data_nxt = right_data;
    end else if (ops.ovw && at_pos) begin
      data_nxt = wr_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (ops.rd && at_pos) ? data_r : '0;

endmodule : ilie_cell
`default_nettype wire

### hdl/ilie_group.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_group: read-out merge for a group of cells
// Registered OR of the masked read words of GW neighboring cells.
// ----------------------------------------------------------------------------
module ilie_group #(
  parameter int GW = 16
) (
  input  wire logic                                  clk,
  input  wire logic [GW-1:0][ilie_pkg::DATA_W-1:0]   words,
  output logic      [ilie_pkg::DATA_W-1:0]           merged
);
  import ilie_pkg::*;

  logic [DATA_W-1:0] merged_r;
  logic [DATA_W-1:0] merged_nxt;

  always_comb begin
    merged_nxt = '0;
    for (int k = 0; k < GW; k++) begin
      merged_nxt = merged_nxt | words[k];
    end
  end

  always_ff @(posedge clk) begin
    merged_r <= merged_nxt;
  end

  assign merged = merged_r;

endmodule : ilie_group
`default_nettype wire

### hdl/indexed_list_insert_erase.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_erase: fixed-capacity ordered list of 64-bit words
// A request runs through the stage 1 and result registers to out_valid; one
// request per cycle, busy is never raised. Insert and erase shift the row of
// cells in parallel; the read word is merged by a registered two-level OR tree.
// Synchronous active-low reset empties the list; cell contents are not reset.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase #(
  parameter int CAPACITY = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ilie_pkg::OP_W-1:0]     in_op,
  input  wire logic [ilie_pkg::POS_W-1:0]    in_position,
  input  wire logic [ilie_pkg::DATA_W-1:0]   in_write_value,
  output logic                               out_valid,
  output logic      [ilie_pkg::DATA_W-1:0]   out_read_value,
  output logic      [ilie_pkg::CNT_W-1:0]    out_item_count,
  output logic                               out_is_empty,
  output logic      [ilie_pkg::ST_W-1:0]     out_status
);
  import ilie_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int GW = 16;
  localparam int NG = (CAPACITY + GW - 1) / GW;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  cell_ops_t         ops;
  status_t           st;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [CW-1:0]     pos_c;
  logic              full;

  assign busy  = 1'b0;
  assign pos_w = PW'(in_position);
  assign cnt_w = PW'(cnt_r);
  assign pos_c = CW'(in_position);
  assign full  = (cnt_r == CAP_C);

  always_comb begin
    ops     = '0;
    st      = ST_DONE;
    cnt_nxt = cnt_r;
    if (start) begin
      unique case (in_op)
        OP_APPEND: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            ops.app = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_INSERT: begin
          if (full) begin
            st = ST_FULL;
          end else if (pos_w > cnt_w) begin
            st = ST_RANGE;
          end else begin
            ops.ins = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_ERASE: begin
          if (pos_w >= cnt_w) begin
            st = ST_RANGE;
          end else begin
            ops.ers = 1'b1;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        OP_OVERWRITE: begin
          if (pos_w >= cnt_w) st = ST_RANGE;
          else ops.ovw = 1'b1;
        end
        OP_READ: begin
          if (pos_w >= cnt_w) st = ST_RANGE;
          else ops.rd = 1'b1;
        end
        OP_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells
  logic [DATA_W-1:0]           cell_q    [CAPACITY];
  logic [DATA_W-1:0]           left_w    [CAPACITY];
  logic [DATA_W-1:0]           right_w   [CAPACITY];
  logic [NG*GW-1:0][DATA_W-1:0] masked;
  logic [NG-1:0][DATA_W-1:0]    grp_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_left
      assign left_w[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_right
      assign right_w[i] = cell_q[i+1];
    end

    ilie_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ops        (ops),
      .pos        (pos_c),
      .cnt        (cnt_r),
      .wr_data    (in_write_value),
      .left_data  (left_w[i]),
      .right_data (right_w[i]),
      .data       (cell_q[i]),
      .rd_data    (masked[i])
    );
  end

  for (genvar j = CAPACITY; j < NG*GW; j++) begin : g_pad
    assign masked[j] = '0;
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    ilie_group #(
      .GW (GW)
    ) u_group (
      .clk    (clk),
      .words  (masked[g*GW +: GW]),
      .merged (grp_q[g])
    );
  end

  // Stage 1: count and status, aligned with the group registers
  logic          s1_valid_r;
  logic [CW-1:0] s1_count_r;
  status_t       s1_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      s1_valid_r <= start;
    end
    s1_count_r  <= cnt_nxt;
    s1_status_r <= st;
  end

  // Stage 2: final merge and result registers
  logic [DATA_W-1:0] rd_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [CNT_W-1:0]  out_item_count_r;
  logic              out_is_empty_r;
  status_t           out_status_r;

  always_comb begin
    rd_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      rd_nxt = rd_nxt | grp_q[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
    out_read_value_r <= rd_nxt;
    out_item_count_r <= CNT_W'(s1_count_r);
    out_is_empty_r   <= (s1_count_r == '0);
    out_status_r     <= s1_status_r;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_item_count = out_item_count_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_status     = out_status_r;

endmodule : indexed_list_insert_erase
`default_nettype wire

### verif/indexed_list_insert_erase_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_tb: self-checking bench for the indexed list
// A driver sends list requests from a queue with random gaps. A monitor keeps
// its own copy of the list, predicts one response per accepted beat and
// compares every response field with the oldest prediction. The stimulus
// starts with a directed set of corner cases, then runs random fill and mixed
// phases so the list reaches full and empties again.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_tb;

  import ilie_pkg::*;

  localparam int          CAPACITY    = 256;
  localparam int unsigned NUM_REQS    = 1650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 10;

  // Op codes the block ignores.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
    int unsigned       gap;
    bit                drain;
  } list_req_t;

  typedef struct {
    logic [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]  count;
    logic              empty;
    status_t           status;
  } list_rsp_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_op          = '0;
  logic [POS_W-1:0]  in_position    = '0;
  logic [DATA_W-1:0] in_write_value = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]  out_item_count;
  logic              out_is_empty;
  logic [ST_W-1:0]   out_status;

  list_req_t   pending_req_q[$];
  list_rsp_t   expected_rsp_q[$];
  int unsigned plan_count  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic [DATA_W-1:0] list_cells[CAPACITY];
  int unsigned       list_count = 0;

  list_req_t   cur_req;
  bit          have_req  = 1'b0;
  int unsigned gap_left  = 0;
  logic        took_beat = 1'b0;

  indexed_list_insert_erase #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_read_value(out_read_value),
    .out_item_count(out_item_count),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Updates the list copy and returns the response the block should give.
  function automatic list_rsp_t apply_list_op(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DATA_W-1:0] wdata);
    list_rsp_t rsp;
    rsp.rdata  = '0;
    rsp.status = ST_DONE;
    case (op)
      OP_APPEND: begin
        if (list_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          list_cells[list_count] = wdata;
          list_count++;
        end
      end
      OP_INSERT: begin
        if (list_count >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else if (pos > list_count) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = list_count; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = wdata;
          list_count++;
        end
      end
      OP_ERASE: begin
        if (pos >= list_count) begin
          rsp.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
        end
      end
      OP_OVERWRITE: begin
        if (pos >= list_count) rsp.status = ST_RANGE;
        else list_cells[pos] = wdata;
      end
      OP_READ: begin
        if (pos >= list_count) rsp.status = ST_RANGE;
        else rsp.rdata = list_cells[pos];
      end
      OP_CLEAR: list_count = 0;
      default: ;
    endcase
    rsp.count = list_count[CNT_W-1:0];
    rsp.empty = (list_count == 0);
    return rsp;
  endfunction

  // plan_count tracks the fill level so positions can be aimed inside the list.
  task automatic push_req(input logic [OP_W-1:0] op, input int unsigned pos,
                          input logic [DATA_W-1:0] wdata, input bit burst,
                          input bit drain);
    list_req_t req;
    req.op    = op;
    req.pos   = pos[POS_W-1:0];
    req.wdata = wdata;
    req.gap   = burst ? 0 : $urandom_range(0, 11);
    req.drain = drain;
    pending_req_q.push_back(req);
    case (op)
      OP_APPEND: if (plan_count < CAPACITY) plan_count++;
      OP_INSERT: if (plan_count < CAPACITY && pos <= plan_count) plan_count++;
      OP_ERASE:  if (pos < plan_count) plan_count--;
      OP_CLEAR:  plan_count = 0;
      default: ;
    endcase
  endtask

  task automatic push_random_req(input int unsigned grow_pct, input bit allow_clear,
                                 input bit burst, input bit drain);
    int unsigned     pick;
    int unsigned     pos;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < grow_pct) begin
      op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_ERASE;
      else if (pick < 55) op = OP_OVERWRITE;
      else if (pick < 92) op = OP_READ;
      else if (pick < 94) op = allow_clear ? OP_CLEAR : OP_READ;
      else op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
    end
    if (plan_count == 0 || $urandom_range(0, 99) < 12) begin
      pos = $urandom_range(0, 255);
    end else if (op == OP_INSERT) begin
      pos = $urandom_range(0, (plan_count > 255) ? 255 : plan_count);
    end else begin
      pos = $urandom_range(0, plan_count - 1);
    end
    push_req(op, pos, {$urandom, $urandom}, burst, drain);
  endtask

  // Driver
  always @(negedge clk) begin
    logic drive;
    drive = 1'b0;
    if (rst_n) begin
      if (start && took_beat) have_req = 1'b0;
      if (!have_req && pending_req_q.size() > 0) begin
        cur_req  = pending_req_q.pop_front();
        gap_left = cur_req.gap;
        have_req = 1'b1;
      end
      if (have_req) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!cur_req.drain || expected_rsp_q.size() == 0) begin
          drive         = 1'b1;
          cur_req.drain = 1'b0;
        end
      end
      start <= drive;
      if (drive) begin
        in_op          <= cur_req.op;
        in_position    <= cur_req.pos;
        in_write_value <= cur_req.wdata;
      end
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    list_rsp_t exp_rsp;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (!rst_n) begin
      took_beat <= 1'b0;
    end else begin
      took_beat <= start && !busy;
      if (start && !busy) begin
        expected_rsp_q.push_back(apply_list_op(in_op, in_position, in_write_value));
      end
      if (out_valid) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response beat");
          error_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_read_value !== exp_rsp.rdata) begin
            $error("read_value: expected %h, actual %h", exp_rsp.rdata, out_read_value);
            error_count++;
          end
          if (out_item_count !== exp_rsp.count) begin
            $error("item_count: expected %0d, actual %0d", exp_rsp.count, out_item_count);
            error_count++;
          end
          if (out_is_empty !== exp_rsp.empty) begin
            $error("is_empty: expected %b, actual %b", exp_rsp.empty, out_is_empty);
            error_count++;
          end
          if (out_status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, out_status);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned seg;
    int unsigned seg_len;
    bit          burst;
    bit          fill_run;
    bit          rnd_burst;

    rnd_burst = ($urandom_range(0, 1) == 1);
    // Corner cases on an empty list, then a short list of four words.
    push_req(OP_READ,      0,   '0, rnd_burst, 1'b0);
    push_req(OP_ERASE,     0,   '1, rnd_burst, 1'b0);
    push_req(OP_OVERWRITE, 0,   '1, rnd_burst, 1'b0);
    push_req(OP_INSERT,    1,   '1, rnd_burst, 1'b0);
    push_req(OP_INSERT,    0,   '1, rnd_burst, 1'b0);
    push_req(OP_APPEND,    255, '0, 1'b0, 1'b0);
    push_req(OP_INSERT,    2,   64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0);
    push_req(OP_INSERT,    1,   64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) push_req(OP_READ, i, '0, 1'b1, 1'b0);
    push_req(OP_READ,      255, '1, 1'b0, 1'b0);
    push_req(OP_OVERWRITE, 3,   64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
    push_req(OP_ERASE,     1,   '0, 1'b0, 1'b0);
    push_req(OP_ERASE,     2,   '0, 1'b0, 1'b0);
    push_req(OP_SPARE_6,   255, '1, 1'b0, 1'b0);
    push_req(OP_SPARE_7,   0,   '1, 1'b0, 1'b0);
    push_req(OP_READ,      0,   '0, 1'b1, 1'b0);
    push_req(OP_READ,      1,   '0, 1'b1, 1'b0);
    push_req(OP_CLEAR,     7,   '1, 1'b0, 1'b0);
    push_req(OP_READ,      0,   '0, 1'b0, 1'b0);
    push_req(OP_ERASE,     0,   '0, 1'b0, 1'b0);
    push_req(OP_APPEND,    0,   64'hDEAD_BEEF_CAFE_F00D, 1'b0, 1'b1);

    // Random phases: fill runs drive the list to full, mixed runs churn it.
    seg = 0;
    while (pending_req_q.size() < NUM_REQS) begin
      fill_run = (seg % 3 == 0);
      seg_len  = fill_run ? 320 : $urandom_range(80, 200);
      burst    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len && pending_req_q.size() < NUM_REQS; i++) begin
        push_random_req(fill_run ? 88 : 45, !fill_run, burst, i == 0);
      end
      seg++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_req_q.size() > 0 || have_req || start) @(posedge clk);
    while (expected_rsp_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
hdl/ilie_pkg.sv
hdl/ilie_cell.sv
hdl/ilie_group.sv
hdl/indexed_list_insert_erase.sv
verif/indexed_list_insert_erase_tb.sv
